// ===== rtl/sgdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgdm_pkg
// Types, register indexes, reset values and fixed-point helpers shared by the
// momentum update engine.
// ----------------------------------------------------------------------------
package sgdm_pkg;

    localparam int unsigned COEF_W     = 16;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned INDEX_W    = 16;
    localparam int unsigned WIDE_W     = VALUE_W + 2;
    localparam int unsigned PROD_W     = VALUE_W + COEF_W;
    localparam int unsigned ACC_W      = PROD_W + 2;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned S_TDATA_W  = INDEX_W + 2 * VALUE_W;
    localparam int unsigned M_TDATA_W  = 2 * VALUE_W;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic        [COEF_W-1:0]  coef_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    localparam logic [CFG_ADDR_W-1:0] REG_LEARNING_RATE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MOMENTUM_FACTOR = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY_FACTOR    = 2'd2;

    localparam coef_t LEARNING_RATE_RST   = 16'd655;
    localparam coef_t MOMENTUM_FACTOR_RST = 16'd58982;
    localparam coef_t DECAY_FACTOR_RST    = 16'd33;

    localparam logic [COEF_W:0] COEF_ONE = {1'b1, {COEF_W{1'b0}}};

    localparam value_t VALUE_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam value_t VALUE_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam acc_t   ROUND_HALF = acc_t'(2 ** (COEF_W - 1));

    // Round to nearest with ties towards plus infinity, dropping the
    // coefficient fraction bits.
    function automatic wide_t round_q(acc_t x);
        acc_t t;
        t = x + ROUND_HALF;
        return wide_t'(t >>> COEF_W);
    endfunction

    function automatic logic is_clipped(wide_t x);
        return (x > wide_t'(VALUE_MAX)) || (x < wide_t'(VALUE_MIN));
    endfunction

    function automatic value_t clip(wide_t x);
        value_t r;
        if (x > wide_t'(VALUE_MAX)) begin
            r = VALUE_MAX;
        end else if (x < wide_t'(VALUE_MIN)) begin
            r = VALUE_MIN;
        end else begin
            r = value_t'(x);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sgdm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgdm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sgdm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/sgd_momentum_weight_decay_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_momentum_weight_decay_update
// Momentum optimiser step with weight decay for one parameter element a beat.
// ----------------------------------------------------------------------------
// The engine takes one beat per clock cycle unless an index hazard or output
// back-pressure holds it, and returns one result beat for each, in order,
// through stages a to e and an output register. Each element's velocity lives
// in a single-port-write memory with a registered read; the velocity is read
// when a beat leaves the first stage and written back when it leaves stage c.
// A beat whose index (taken modulo the store depth) matches one of the two
// beats ahead of it waits until that velocity has been written. After reset a
// clearing pass writes zero to every velocity entry, one a cycle, so s_tready
// stays low until the pass ends; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module sgd_momentum_weight_decay_update #(
    parameter int unsigned VELOCITY_DEPTH = 65536
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // element_index, param_value, grad_value
    input  wire logic [sgdm_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // updated_param, updated_velocity
    output logic      [sgdm_pkg::M_TDATA_W-1:0]      m_tdata,
    // saturated
    output logic      [0:0]                          m_tuser,
    input  wire logic                                cfg_we,
    input  wire logic [sgdm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [sgdm_pkg::COEF_W-1:0]         cfg_wdata
);

    localparam int unsigned ADDR_W  = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
    localparam int unsigned INDEX_W = sgdm_pkg::INDEX_W;
    localparam int unsigned VALUE_W = sgdm_pkg::VALUE_W;
    localparam int unsigned COEF_W  = sgdm_pkg::COEF_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VELOCITY_DEPTH - 1);

    // Configuration
    sgdm_pkg::coef_t lr_reg, mom_reg, decay_reg;

    // Control
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg, valid_e_reg;
    logic              m_tvalid_reg;

    // Stage payloads
    logic [INDEX_W-1:0]       idx_a_reg;
    sgdm_pkg::value_t         p_a_reg, g_a_reg;
    sgdm_pkg::prod_t          pd_a_reg;
    logic [ADDR_W-1:0]        addr_b_reg;
    sgdm_pkg::value_t         p_b_reg, d_b_reg;
    logic                     sat_b_reg;
    logic [ADDR_W-1:0]        addr_c_reg;
    sgdm_pkg::value_t         p_c_reg;
    sgdm_pkg::prod_t          pm_c_reg, pdd_c_reg;
    logic                     sat_c_reg;
    sgdm_pkg::value_t         p_d_reg, vn_d_reg;
    logic                     sat_d_reg;
    sgdm_pkg::value_t         p_e_reg, vn_e_reg;
    sgdm_pkg::prod_t          pl_e_reg;
    logic                     sat_e_reg;
    sgdm_pkg::value_t         par_o_reg, vel_o_reg;
    logic                     sat_o_reg;

    // Input fields
    logic [INDEX_W-1:0] s_idx;
    sgdm_pkg::value_t   s_param, s_grad;

    assign s_idx   = s_tdata[INDEX_W-1:0];
    assign s_param = $signed(s_tdata[INDEX_W +: VALUE_W]);
    assign s_grad  = $signed(s_tdata[INDEX_W + VALUE_W +: VALUE_W]);

    // Flow control: a stage moves when the next is free; hazards hold stage a.
    logic out_free, free_e, free_d, free_c, free_b;
    logic mv_e, mv_d, mv_c, mv_b, mv_a;
    logic hazard, s_acc;
    logic [ADDR_W-1:0] addr_a;

    assign out_free = !m_tvalid_reg || m_tready;
    assign mv_e     = valid_e_reg && out_free;
    assign free_e   = !valid_e_reg || out_free;
    assign mv_d     = valid_d_reg && free_e;
    assign free_d   = !valid_d_reg || free_e;
    assign mv_c     = valid_c_reg && free_d;
    assign free_c   = !valid_c_reg || free_d;
    assign mv_b     = valid_b_reg && free_c;
    assign free_b   = !valid_b_reg || free_c;
    assign hazard   = (valid_b_reg && (addr_b_reg == addr_a))
                   || (valid_c_reg && (addr_c_reg == addr_a));
    assign mv_a     = valid_a_reg && free_b && !hazard;
    assign s_tready = !clearing_reg && (!valid_a_reg || mv_a);
    assign s_acc    = s_tvalid && s_tready;

    // Element index to store address.
    if (VELOCITY_DEPTH >= 2 ** INDEX_W) begin : g_addr_direct
        assign addr_a = ADDR_W'(idx_a_reg);
    end else if ((VELOCITY_DEPTH & (VELOCITY_DEPTH - 1)) == 0) begin : g_addr_mask
        assign addr_a = ADDR_W'(idx_a_reg & INDEX_W'(VELOCITY_DEPTH - 1));
    end else begin : g_addr_recip
        localparam int unsigned RECIP_SH = 32;
        localparam logic [RECIP_SH-1:0] RECIP =
            RECIP_SH'((64'd1 << RECIP_SH) / VELOCITY_DEPTH);
        localparam logic [INDEX_W:0] DEPTH_C = (INDEX_W + 1)'(VELOCITY_DEPTH);

        logic [INDEX_W+RECIP_SH-1:0] rq_reg;
        logic [INDEX_W-1:0]          quot;
        logic [2*INDEX_W-1:0]        qd;
        logic [INDEX_W:0]            r_est;

        always_ff @(posedge aclk) begin
            if (s_acc) begin
                rq_reg <= {{RECIP_SH{1'b0}}, s_idx} * {{INDEX_W{1'b0}}, RECIP};
            end
        end

        // The estimated quotient is at most one short, so one correction step.
        assign quot   = rq_reg[INDEX_W+RECIP_SH-1:RECIP_SH];
        assign qd     = quot * DEPTH_C[INDEX_W-1:0];
        assign r_est  = {1'b0, idx_a_reg} - qd[INDEX_W:0];
        assign addr_a = ADDR_W'((r_est >= DEPTH_C) ? (r_est - DEPTH_C) : r_est);
    end

    // Velocity store
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    sgdm_pkg::value_t      ram_wdata;
    logic [VALUE_W-1:0]    ram_rdata;

    // Arithmetic between stages
    sgdm_pkg::prod_t       pd_next, pm_next, pdd_next, pl_next;
    sgdm_pkg::wide_t       d_full, vn_full, p_full;
    sgdm_pkg::value_t      d_next, vn_next, par_next, v_b;
    logic                  sat_b_next, sat_d_next, sat_o_next;
    logic signed [COEF_W:0]   decay_s, mom_s, lr_s;
    logic        [COEF_W:0]   one_minus_mom;
    logic signed [COEF_W+1:0] om_s;

    assign decay_s       = $signed({1'b0, decay_reg});
    assign mom_s         = $signed({1'b0, mom_reg});
    assign lr_s          = $signed({1'b0, lr_reg});
    assign one_minus_mom = sgdm_pkg::COEF_ONE - {1'b0, mom_reg};
    assign om_s          = $signed({1'b0, one_minus_mom});
    assign v_b           = $signed(ram_rdata);

    always_comb begin
        pd_next    = sgdm_pkg::prod_t'(s_param) * sgdm_pkg::prod_t'(decay_s);
        d_full     = sgdm_pkg::wide_t'(g_a_reg)
                   + sgdm_pkg::round_q(sgdm_pkg::acc_t'(pd_a_reg));
        d_next     = sgdm_pkg::clip(d_full);
        sat_b_next = sgdm_pkg::is_clipped(d_full);
        pm_next    = sgdm_pkg::prod_t'(v_b) * sgdm_pkg::prod_t'(mom_s);
        pdd_next   = sgdm_pkg::prod_t'(d_b_reg) * sgdm_pkg::prod_t'(om_s);
        vn_full    = sgdm_pkg::round_q(sgdm_pkg::acc_t'(pm_c_reg)
                                     + sgdm_pkg::acc_t'(pdd_c_reg));
        vn_next    = sgdm_pkg::clip(vn_full);
        sat_d_next = sat_c_reg || sgdm_pkg::is_clipped(vn_full);
        pl_next    = sgdm_pkg::prod_t'(vn_d_reg) * sgdm_pkg::prod_t'(lr_s);
        p_full     = sgdm_pkg::wide_t'(p_e_reg)
                   - sgdm_pkg::round_q(sgdm_pkg::acc_t'(pl_e_reg));
        par_next   = sgdm_pkg::clip(p_full);
        sat_o_next = sat_e_reg || sgdm_pkg::is_clipped(p_full);
    end

    assign ram_we    = clearing_reg || mv_c;
    assign ram_waddr = clearing_reg ? clr_addr_reg : addr_c_reg;
    assign ram_wdata = clearing_reg ? '0 : vn_next;

    sgdm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VELOCITY_DEPTH)
    ) u_velocity_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (mv_a),
        .raddr (addr_a),
        .rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg       <= sgdm_pkg::LEARNING_RATE_RST;
            mom_reg      <= sgdm_pkg::MOMENTUM_FACTOR_RST;
            decay_reg    <= sgdm_pkg::DECAY_FACTOR_RST;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            valid_a_reg  <= 1'b0;
            valid_b_reg  <= 1'b0;
            valid_c_reg  <= 1'b0;
            valid_d_reg  <= 1'b0;
            valid_e_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    sgdm_pkg::REG_LEARNING_RATE: begin
                        lr_reg <= cfg_wdata;
                    end
                    sgdm_pkg::REG_MOMENTUM_FACTOR: begin
                        mom_reg <= cfg_wdata;
                    end
                    sgdm_pkg::REG_DECAY_FACTOR: begin
                        decay_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (!valid_a_reg || mv_a) begin
                valid_a_reg <= s_acc;
            end
            if (free_b) begin
                valid_b_reg <= mv_a;
            end
            if (free_c) begin
                valid_c_reg <= mv_b;
            end
            if (free_d) begin
                valid_d_reg <= mv_c;
            end
            if (free_e) begin
                valid_e_reg <= mv_d;
            end
            if (out_free) begin
                m_tvalid_reg <= mv_e;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            idx_a_reg <= s_idx;
            p_a_reg   <= s_param;
            g_a_reg   <= s_grad;
            pd_a_reg  <= pd_next;
        end
        if (mv_a) begin
            addr_b_reg <= addr_a;
            p_b_reg    <= p_a_reg;
            d_b_reg    <= d_next;
            sat_b_reg  <= sat_b_next;
        end
        if (mv_b) begin
            addr_c_reg <= addr_b_reg;
            p_c_reg    <= p_b_reg;
            pm_c_reg   <= pm_next;
            pdd_c_reg  <= pdd_next;
            sat_c_reg  <= sat_b_reg;
        end
        if (mv_c) begin
            p_d_reg   <= p_c_reg;
            vn_d_reg  <= vn_next;
            sat_d_reg <= sat_d_next;
        end
        if (mv_d) begin
            p_e_reg   <= p_d_reg;
            vn_e_reg  <= vn_d_reg;
            pl_e_reg  <= pl_next;
            sat_e_reg <= sat_d_reg;
        end
        if (mv_e) begin
            par_o_reg <= par_next;
            vel_o_reg <= vn_e_reg;
            sat_o_reg <= sat_o_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {vel_o_reg, par_o_reg};
    assign m_tuser[0] = sat_o_reg;

    // The pipeline is empty for the whole clearing pass.
    a_empty_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !(valid_a_reg || valid_b_reg || valid_c_reg
                           || valid_d_reg || valid_e_reg || m_tvalid_reg))
        else $error("beat in flight during velocity clearing pass");

    // A beat that has read the store never shares an address with an older
    // beat whose velocity is still to be written.
    a_no_read_before_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_b_reg && valid_c_reg) |-> (addr_b_reg != addr_c_reg))
        else $error("velocity read overtook a pending write to the same entry");

    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clearing_reg |=> !clearing_reg)
        else $error("clearing pass restarted without reset");

    a_clear_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> ($past(clr_addr_reg) == LAST_ADDR))
        else $error("clearing pass ended before the last entry");

endmodule
`default_nettype wire

// ===== dv/sgd_momentum_weight_decay_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_momentum_weight_decay_update_test
// Self-checking bench for the momentum update engine. Parameter and gradient
// beats are streamed in under random back-pressure and idle gaps, a local
// fixed-point model tracks every element's velocity, and each result beat is
// compared field by field with the value predicted when its input was taken.
// ----------------------------------------------------------------------------
module sgd_momentum_weight_decay_update_test;

    import sgdm_pkg::*;

    typedef struct packed {
        value_t param;
        value_t velocity;
        logic   clipped;
    } update_t;

    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;
    localparam longint unsigned TIMEOUT_CYCLES = 3_000_000;
    localparam int unsigned IDLE_PERCENT = 29;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [COEF_W-1:0]      cfg_wdata = '0;

    coef_t rate_q = LEARNING_RATE_RST;
    coef_t momentum_q = MOMENTUM_FACTOR_RST;
    coef_t decay_q = DECAY_FACTOR_RST;
    int    velocity_mem [0:65535];

    update_t     pending_updates [$];
    update_t     got_update;
    update_t     want_update;
    bit          no_idle = 1'b0;
    logic [15:0] last_index = '0;
    int          beats_sent = 0;
    int          results_seen = 0;
    int          clipped_seen = 0;
    int          settings_used = 1;
    int          mismatch_count = 0;

    sgd_momentum_weight_decay_update dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("Timed out with %0d results still pending.", pending_updates.size());
        $display("[sgd_momentum_weight_decay_update] ERROR");
        $finish;
    end

    // Rounds away the sixteen coefficient fraction bits, ties going upwards.
    function automatic longint fix_round(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint saturate(longint x, inout bit clipped);
        if (x > longint'(VALUE_MAX)) begin
            clipped = 1'b1;
            return longint'(VALUE_MAX);
        end
        if (x < longint'(VALUE_MIN)) begin
            clipped = 1'b1;
            return longint'(VALUE_MIN);
        end
        return x;
    endfunction

    function automatic update_t predict_update(logic [15:0] idx, value_t p, value_t g);
        update_t r;
        bit      clipped;
        longint  step;
        longint  vel;
        longint  par;
        clipped = 1'b0;
        step = saturate(longint'(g) + fix_round(longint'(p) * longint'(decay_q)), clipped);
        vel = longint'(momentum_q) * longint'(velocity_mem[idx])
            + (64'sd65536 - longint'(momentum_q)) * step;
        vel = saturate(fix_round(vel), clipped);
        par = saturate(longint'(p) - fix_round(vel * longint'(rate_q)), clipped);
        velocity_mem[idx] = int'(vel);
        r.param = value_t'(par);
        r.velocity = value_t'(vel);
        r.clipped = clipped;
        return r;
    endfunction

    function automatic void report_mismatch(string what, longint want, longint got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch on %s at %0t: expected %0d, got %0d.", what, $realtime, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got_update.param = value_t'(m_tdata[31:0]);
            got_update.velocity = value_t'(m_tdata[63:32]);
            got_update.clipped = m_tuser[0];
            if (got_update.clipped) begin
                clipped_seen++;
            end
            if (pending_updates.size() == 0) begin
                report_mismatch("unexpected result beat", 0, got_update.param);
            end else begin
                want_update = pending_updates.pop_front();
                if (got_update.param !== want_update.param) begin
                    report_mismatch("updated_param", want_update.param, got_update.param);
                end
                if (got_update.velocity !== want_update.velocity) begin
                    report_mismatch("updated_velocity", want_update.velocity,
                                    got_update.velocity);
                end
                if (got_update.clipped !== want_update.clipped) begin
                    report_mismatch("saturated", want_update.clipped, got_update.clipped);
                end
            end
        end
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic send_update(input logic [15:0] idx, input value_t p, input value_t g);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {g, p, idx};
        do @(posedge aclk); while (!s_tready);
        pending_updates.push_back(predict_update(idx, p, g));
        last_index = idx;
        beats_sent++;
    endtask

    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_coef(input logic [CFG_ADDR_W-1:0] addr, input coef_t value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (addr)
            REG_LEARNING_RATE: rate_q = value;
            REG_MOMENTUM_FACTOR: momentum_q = value;
            REG_DECAY_FACTOR: decay_q = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_coefs(input coef_t lr, input coef_t mom, input coef_t dec);
        write_coef(REG_LEARNING_RATE, lr);
        write_coef(REG_MOMENTUM_FACTOR, mom);
        write_coef(REG_DECAY_FACTOR, dec);
        settings_used++;
    endtask

    function automatic value_t random_value();
        case ($urandom_range(9))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2, 3, 4: return value_t'($urandom_range(0, 32'h000F_FFFF)) - value_t'(32'h0008_0000);
            default: return value_t'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_index();
        case ($urandom_range(9))
            0, 1: return last_index;
            2, 3, 4, 5: return 16'($urandom_range(7));
            6: return 16'hFFFF - 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_update(16'd0, 32'sh0001_0000, 32'sh0001_0000);
        send_update(16'd0, 32'sh0001_0000, 32'sh0001_0000);
        send_update(16'd1, -32'sh0001_0000, 32'sh0000_8000);
        wait_idle(8);
    endtask

    task automatic test_field_extremes();
        send_update(16'hFFFF, VALUE_MAX, VALUE_MAX);
        send_update(16'hFFFF, VALUE_MIN, VALUE_MIN);
        send_update(16'h0000, VALUE_MIN, VALUE_MAX);
        send_update(16'h0000, VALUE_MAX, VALUE_MIN);
        send_update(16'h8000, 32'sd0, 32'sd0);
        send_update(16'h7FFF, -32'sd1, 32'sd1);
        wait_idle(8);
    endtask

    task automatic test_saturation();
        set_coefs(16'hFFFF, 16'h0000, 16'hFFFF);
        send_update(16'd2, VALUE_MAX, VALUE_MAX);
        send_update(16'd3, VALUE_MIN, VALUE_MIN);
        send_update(16'd4, VALUE_MIN, VALUE_MAX);
        send_update(16'd5, VALUE_MAX, VALUE_MIN);
        wait_idle(8);
    endtask

    // Back-to-back beats on one element must each see the velocity that the
    // beat ahead of them wrote.
    task automatic test_index_repeats();
        set_coefs(16'd6554, 16'd32768, 16'd655);
        no_idle = 1'b1;
        for (int i = 0; i < 5; i++) begin
            send_update(16'd9, 32'sh0002_0000, value_t'((i + 1) * 32'sh0000_4000));
        end
        send_update(16'd10, -32'sh0003_0000, 32'sh0001_0000);
        send_update(16'd9, 32'sh0002_0000, -32'sh0001_0000);
        send_update(16'd10, -32'sh0003_0000, 32'sh0001_0000);
        no_idle = 1'b0;
        wait_idle(8);
    endtask

    task automatic test_ignored_register();
        write_coef(REG_NONE, 16'h1234);
        send_update(16'd11, 32'sh0005_0000, -32'sh0000_2000);
        send_update(16'd11, -32'sh0005_0000, 32'sh0000_2000);
        wait_idle(8);
    endtask

    task automatic test_random_traffic(input int count, input coef_t lr, input coef_t mom,
                                       input coef_t dec, input bit steady);
        set_coefs(lr, mom, dec);
        no_idle = steady;
        for (int i = 0; i < count; i++) begin
            send_update(random_index(), random_value(), random_value());
        end
        no_idle = 1'b0;
        wait_idle(8);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_saturation();
        test_index_repeats();
        test_ignored_register();
        test_random_traffic(140, 16'd655, 16'd58982, 16'd33, 1'b0);
        test_random_traffic(130, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        test_random_traffic(130, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        test_random_traffic(130, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        test_random_traffic(130, coef_t'($urandom), coef_t'($urandom), coef_t'($urandom), 1'b0);
        test_random_traffic(130, coef_t'($urandom), coef_t'($urandom), coef_t'($urandom), 1'b0);
        wait_idle(20);
        $display("Sent %0d beats and checked %0d results across %0d coefficient settings.",
                 beats_sent, results_seen, settings_used);
        $display("%0d results were saturated; %0d mismatches, %0d results outstanding.",
                 clipped_seen, mismatch_count, pending_updates.size());
        if (mismatch_count == 0 && pending_updates.size() == 0) begin
            $display("[sgd_momentum_weight_decay_update] OK");
        end else begin
            $display("[sgd_momentum_weight_decay_update] ERROR");
        end
        $finish;
    end

endmodule
